// ----- design/olar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package olar_pkg;

    // Storage geometry of the list.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed widths of the port fields.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int LEN_W   = 5;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    // Derived widths: entry index and entry count.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RM_READ,
        S_RM_CHECK,
        S_DP_READ,
        S_DP_OUT
    } t_state;

    // Result of one pass through the shared compare and index unit.
    typedef struct packed {
        logic             eq;
        logic [IDX_W-1:0] idx_next;
        logic             at_end;
    } t_step;

    // Keep the low DATA_WIDTH bits of an input value, zero filled above.
    function automatic logic [DATA_WIDTH-1:0] to_entry(input logic [VALUE_W-1:0] v);
        logic [DATA_WIDTH+VALUE_W-1:0] ext;
        ext = {{DATA_WIDTH{1'b0}}, v};
        return ext[DATA_WIDTH-1:0];
    endfunction

    // Bring a stored entry back to the port width.
    function automatic logic [VALUE_W-1:0] from_entry(input logic [DATA_WIDTH-1:0] e);
        logic [DATA_WIDTH+VALUE_W-1:0] ext;
        ext = {{VALUE_W{1'b0}}, e};
        return ext[VALUE_W-1:0];
    endfunction

    // Low bits of an index for the position field.
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] ext;
        ext = {{POS_W{1'b0}}, idx};
        return ext[POS_W-1:0];
    endfunction

    // Low bits of a count for the length field.
    function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+LEN_W-1:0] ext;
        ext = {{LEN_W{1'b0}}, cnt};
        return ext[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/ordered_list_append_remove_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH signed values kept in insertion order. An
// operation is taken when start is high and busy is low. Append, an unused
// code and any operation on an empty list give their single result in the
// cycle after the transfer. Remove walks the stored entries through one
// compare unit and one RAM read port, a read state and a check state per
// entry, closing the gap behind the first match before its single result.
// Dump streams the entries from head to tail, reading then showing each,
// the final one marked by last. Each result stands on the outputs for exactly
// one cycle while o_valid is high; the receiver cannot stall it, so it must
// take every result in that cycle. busy stays high through a remove or dump
// and falls in the cycle that shows its last result, so the next operation
// can be taken at the end of that cycle.
module ordered_list_append_remove_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [olar_pkg::FUNC_W-1:0]   i_func,
    input  wire logic signed [olar_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    output logic signed [olar_pkg::VALUE_W-1:0] o_data,
    output logic      [olar_pkg::POS_W-1:0]    o_position,
    output logic                               o_last,
    output logic      [olar_pkg::LEN_W-1:0]    o_length,
    output logic      [olar_pkg::STAT_W-1:0]   o_status
);

    olar_pkg::t_state r_state, n_state;

    logic [olar_pkg::CNT_W-1:0]      r_count, n_count;
    logic [olar_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic                            r_found, n_found;
    logic [olar_pkg::DATA_WIDTH-1:0] r_key, n_key;

    logic                            n_valid;
    logic [olar_pkg::VALUE_W-1:0]    n_data;
    logic [olar_pkg::POS_W-1:0]      n_pos;
    logic                            n_last;
    logic [olar_pkg::LEN_W-1:0]      n_len;
    logic [olar_pkg::STAT_W-1:0]     n_status;

    logic                            ram_we;
    logic [olar_pkg::IDX_W-1:0]      ram_waddr;
    logic [olar_pkg::DATA_WIDTH-1:0] ram_wdata;
    logic [olar_pkg::DATA_WIDTH-1:0] ram_rdata;

    olar_pkg::t_step                 step;
    logic                            accept;
    logic                            full;
    logic                            empty;
    logic                            found_now;
    logic [olar_pkg::DATA_WIDTH-1:0] in_entry;

    assign busy      = (r_state != olar_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign full      = (r_count == olar_pkg::CNT_W'(olar_pkg::DEPTH));
    assign empty     = (r_count == '0);
    assign found_now = r_found || step.eq;
    assign in_entry  = olar_pkg::to_entry(i_value);

    // Entry store.
    olar_ram #(
        .WIDTH (olar_pkg::DATA_WIDTH),
        .DEPTH (olar_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Shared compare and index unit.
    olar_step u_step (
        .i_entry (ram_rdata),
        .i_key   (r_key),
        .i_idx   (r_idx),
        .i_count (r_count),
        .o_step  (step)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olar_pkg::S_IDLE: begin
                if (accept && !empty) begin
                    unique case (i_func)
                        olar_pkg::FUNC_REMOVE: n_state = olar_pkg::S_RM_READ;
                        olar_pkg::FUNC_DUMP:   n_state = olar_pkg::S_DP_READ;
                        default:               n_state = olar_pkg::S_IDLE;
                    endcase
                end
            end
            olar_pkg::S_RM_READ:  n_state = olar_pkg::S_RM_CHECK;
            olar_pkg::S_RM_CHECK: begin
                n_state = step.at_end ? olar_pkg::S_IDLE : olar_pkg::S_RM_READ;
            end
            olar_pkg::S_DP_READ:  n_state = olar_pkg::S_DP_OUT;
            olar_pkg::S_DP_OUT: begin
                n_state = step.at_end ? olar_pkg::S_IDLE : olar_pkg::S_DP_READ;
            end
            default: n_state = olar_pkg::S_IDLE;
        endcase
    end

    // Datapath control, RAM writes and result fields.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_found   = r_found;
        n_key     = r_key;
        n_valid   = 1'b0;
        n_data    = '0;
        n_pos     = '0;
        n_last    = 1'b1;
        n_len     = olar_pkg::to_len(r_count);
        n_status  = olar_pkg::STAT_OK;
        ram_we    = 1'b0;
        ram_waddr = r_count[olar_pkg::IDX_W-1:0];
        ram_wdata = in_entry;
        unique case (r_state)
            olar_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_key   = in_entry;
                    unique case (i_func) inside
                        olar_pkg::FUNC_APPEND: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = olar_pkg::STAT_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + olar_pkg::CNT_W'(1);
                                n_len   = olar_pkg::to_len(r_count + olar_pkg::CNT_W'(1));
                            end
                        end
                        olar_pkg::FUNC_REMOVE, olar_pkg::FUNC_DUMP: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = olar_pkg::STAT_EMPTY;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            olar_pkg::S_RM_READ: begin
                // The RAM read of the current index is under way.
            end
            olar_pkg::S_RM_CHECK: begin
                // Behind the match every entry moves down by one place.
                if (r_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx - olar_pkg::IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                n_found = found_now;
                n_idx   = step.idx_next;
                if (step.at_end) begin
                    n_valid = 1'b1;
                    if (found_now) begin
                        n_count = r_count - olar_pkg::CNT_W'(1);
                        n_len   = olar_pkg::to_len(r_count - olar_pkg::CNT_W'(1));
                    end else begin
                        n_status = olar_pkg::STAT_NOT_FOUND;
                    end
                end
            end
            olar_pkg::S_DP_READ: begin
                // The RAM read of the current index is under way.
            end
            olar_pkg::S_DP_OUT: begin
                n_valid = 1'b1;
                n_data  = olar_pkg::from_entry(ram_rdata);
                n_pos   = olar_pkg::to_pos(r_idx);
                n_last  = step.at_end;
                n_idx   = step.idx_next;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olar_pkg::S_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
            r_idx   <= n_idx;
            o_valid <= n_valid;
        end
    end

    // Key and result payload registers.
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        o_data     <= n_data;
        o_position <= n_pos;
        o_last     <= n_last;
        o_length   <= n_len;
        o_status   <= n_status;
    end

endmodule

`default_nettype wire

// ----- design/olar_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module olar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one read port; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/olar_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module olar_step (
    input  wire logic [olar_pkg::DATA_WIDTH-1:0] i_entry,
    input  wire logic [olar_pkg::DATA_WIDTH-1:0] i_key,
    input  wire logic [olar_pkg::IDX_W-1:0]      i_idx,
    input  wire logic [olar_pkg::CNT_W-1:0]      i_count,
    output olar_pkg::t_step                      o_step
);

    logic [olar_pkg::CNT_W-1:0] inc;

    // The index plus one never exceeds the depth, so it fits the count width.
    assign inc = olar_pkg::CNT_W'(i_idx) + olar_pkg::CNT_W'(1);

    // Compare the entry just read with the key and advance the walk index.
    always_comb begin
        o_step.eq       = (i_entry == i_key);
        o_step.idx_next = inc[olar_pkg::IDX_W-1:0];
        o_step.at_end   = (inc == i_count);
    end

endmodule

`default_nettype wire
